@@ src/sacl_pkg.sv @@
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int MaxWays    = 8;
  localparam int WayBits    = $clog2(MaxWays);
  localparam int MaxSetBits = 6;
  localparam int LineBits   = MaxSetBits + WayBits;
  localparam int AddrWidth  = 64;
  localparam int RankBits   = 3;
  localparam int CntWidth   = 32;

  localparam logic [CntWidth-1:0] CntMax = '1;

  // configuration register indexes
  localparam logic [1:0] RegSetBits  = 2'd0;
  localparam logic [1:0] RegOffBits  = 2'd1;
  localparam logic [1:0] RegWays     = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DECIDE,
    ST_UPD
  } state_t;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

endpackage

@@ src/set_assoc_cache_lru_tag_sim_top.sv @@
// channel | handshake            | payload
// --------+----------------------+---------------------------------------------
// req     | req_valid, req_stall | func, address
// rsp     | rsp_valid, rsp_stall | outcome, way_used, hit/miss/eviction_total,
//         |                      | last_of_run
// cfg     | cfg_valid, cfg_ready | cfg_index, cfg_data (cfg_ready always high)
//
// each lookup walks the ways of one set through a single read port and then
// writes the ranks back one way a cycle; a modify item runs two lookups
// after reset a clearing pass zeroes all 512 entries of the line stores, the
// request side is stalled meanwhile, configuration writes are taken as ever
// a result waits in the output register; the block only holds in its decide
// step while that register is full and stalled
`timescale 1ns / 1ps

module set_assoc_cache_lru_tag_sim_top import sacl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // request items
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 func,
  input  logic [AddrWidth-1:0] address,
  // result items
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [1:0]           outcome,
  output logic [WayBits-1:0]   way_used,
  output logic [CntWidth-1:0]  hit_total,
  output logic [CntWidth-1:0]  miss_total,
  output logic [CntWidth-1:0]  eviction_total,
  output logic                 last_of_run,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [5:0]           cfg_data
);

  // line stores: {valid, tag} and rank, one entry per way of every set
  logic [AddrWidth:0]  tag_mem  [2**LineBits];
  logic [RankBits-1:0] rank_mem [2**LineBits];

  state_t state, state_next;

  // configuration
  logic [2:0] set_index_bits;
  logic [5:0] block_offset_bits;
  logic [3:0] ways_in_use;

  // item and lookup registers
  logic                  func_q;
  logic [AddrWidth-1:0]  addr_q;
  logic                  pass;          // second lookup of a modify
  logic [AddrWidth-1:0]  tag;
  logic [MaxSetBits-1:0] set_idx;
  logic [LineBits-1:0]   clr_idx;
  logic [WayBits:0]      rd_i;
  logic                  pend;
  logic [WayBits-1:0]    pend_i;
  logic [WayBits-1:0]    wr_i;

  // scan results
  logic                  hit_found, inv_found;
  logic [WayBits-1:0]    hit_way, inv_way, min_way;
  logic [RankBits-1:0]   min_rank;
  logic [RankBits-1:0]   rk_loc [MaxWays];
  logic [WayBits-1:0]    sel_way;
  logic                  sel_hit;

  // registered read data
  logic [AddrWidth:0]    tag_q;
  logic [RankBits-1:0]   rank_q;

  logic [CntWidth-1:0]   hits_seen, misses_seen, evictions_seen;
  logic [CntWidth-1:0]   hits_next, misses_next, evictions_next;

  logic [1:0]            rsp_outcome;
  logic [WayBits-1:0]    rsp_way;
  logic                  rsp_last;

  // derived configuration
  logic [2:0]            s_eff;
  logic [3:0]            ways;
  logic [3:0]            ways_dec;
  logic [WayBits-1:0]    ways_m1;
  logic [6:0]            tag_shift;
  logic [AddrWidth-1:0]  off_shifted;
  logic [MaxSetBits-1:0] set_mask;

  // control
  logic                  slot_free;
  logic                  emit;
  logic                  issue;
  logic                  scan_last;
  logic                  upd_last;
  outcome_t              dec_outcome;
  logic [WayBits-1:0]    dec_way;
  logic                  tag_we, rank_we;
  logic [LineBits-1:0]   wr_addr, rd_addr;
  logic [AddrWidth:0]    tag_wd;
  logic [RankBits-1:0]   rank_wd;

  // set bits saturate at the largest set count, ways clamp to 1..MaxWays
  assign s_eff    = (set_index_bits > 3'(MaxSetBits)) ? 3'(MaxSetBits) : set_index_bits;
  assign ways     = (ways_in_use == 4'd0) ? 4'd1 :
                    (ways_in_use > 4'(MaxWays)) ? 4'(MaxWays) : ways_in_use;
  assign ways_dec = ways - 4'd1;
  assign ways_m1  = ways_dec[WayBits-1:0];

  assign tag_shift   = {4'd0, s_eff} + {1'b0, block_offset_bits};
  assign off_shifted = addr_q >> block_offset_bits;
  assign set_mask    = ~({MaxSetBits{1'b1}} << s_eff);

  assign slot_free = !rsp_valid || !rsp_stall;
  assign scan_last = pend && (pend_i == ways_m1);
  assign upd_last  = (wr_i == ways_m1);
  assign issue     = (state == ST_SCAN) && (rd_i < ways);
  assign rd_addr   = {set_idx, rd_i[WayBits-1:0]};

  // hit first, then the first empty way, then the lowest-ranked way
  always_comb begin
    if (hit_found) begin
      dec_outcome = OUT_HIT;
      dec_way     = hit_way;
    end else if (inv_found) begin
      dec_outcome = OUT_FILL;
      dec_way     = inv_way;
    end else begin
      dec_outcome = OUT_EVICT;
      dec_way     = min_way;
    end
  end

  always_comb begin
    hits_next      = hits_seen;
    misses_next    = misses_seen;
    evictions_next = evictions_seen;
    if (hit_found) begin
      if (hits_seen != CntMax) hits_next = hits_seen + 1'b1;
    end else begin
      if (misses_seen != CntMax) misses_next = misses_seen + 1'b1;
      if (!inv_found && evictions_seen != CntMax) evictions_next = evictions_seen + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (clr_idx == {LineBits{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:   if (req_valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_SCAN;
      ST_SCAN:   if (scan_last) state_next = ST_DECIDE;
      ST_DECIDE: if (slot_free) state_next = ST_UPD;
      ST_UPD: begin
        if (upd_last) begin
          state_next = (func_q && !pass) ? ST_PREP : ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer and store write ports
  always_comb begin
    req_stall = (state != ST_IDLE);
    emit      = (state == ST_DECIDE) && slot_free;
    rank_we   = 1'b0;
    tag_we    = 1'b0;
    wr_addr   = {set_idx, wr_i};
    tag_wd    = {1'b1, tag};
    rank_wd   = '0;
    case (state)
      ST_CLEAR: begin
        rank_we = 1'b1;
        tag_we  = 1'b1;
        wr_addr = clr_idx;
        tag_wd  = '0;
      end
      ST_UPD: begin
        rank_we = 1'b1;
        tag_we  = (wr_i == sel_way) && !sel_hit;
        // touched way to the top, ranks above its old rank move down one
        if (wr_i == sel_way) begin
          rank_wd = ways_m1;
        end else if (rk_loc[wr_i] > rk_loc[sel_way]) begin
          rank_wd = rk_loc[wr_i] - 1'b1;
        end else begin
          rank_wd = rk_loc[wr_i];
        end
      end
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_CLEAR;
      clr_idx           <= '0;
      rsp_valid         <= 1'b0;
      hits_seen         <= '0;
      misses_seen       <= '0;
      evictions_seen    <= '0;
      set_index_bits    <= 3'd1;
      block_offset_bits <= 6'd4;
      ways_in_use       <= 4'd1;
      pend              <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= issue;
      if (state == ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (emit) begin
        rsp_valid      <= 1'b1;
        hits_seen      <= hits_next;
        misses_seen    <= misses_next;
        evictions_seen <= evictions_next;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegSetBits: set_index_bits    <= cfg_data[2:0];
          RegOffBits: block_offset_bits <= cfg_data;
          RegWays:    ways_in_use       <= cfg_data[3:0];
          default: ;
        endcase
      end
    end
  end

  // lookup datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_valid) begin
      func_q <= func;
      addr_q <= address;
      pass   <= 1'b0;
    end
    if (state == ST_UPD && upd_last) pass <= 1'b1;

    if (state == ST_PREP) begin
      tag       <= tag_shift[6] ? '0 : (addr_q >> tag_shift[5:0]);
      set_idx   <= off_shifted[MaxSetBits-1:0] & set_mask;
      rd_i      <= '0;
      hit_found <= 1'b0;
      inv_found <= 1'b0;
    end
    if (issue) begin
      rd_i   <= rd_i + 1'b1;
      pend_i <= rd_i[WayBits-1:0];
    end

    // compare the way read in the previous cycle
    if (state == ST_SCAN && pend) begin
      rk_loc[pend_i] <= rank_q;
      if (!hit_found && tag_q[AddrWidth] && tag_q[AddrWidth-1:0] == tag) begin
        hit_found <= 1'b1;
        hit_way   <= pend_i;
      end
      if (!inv_found && !tag_q[AddrWidth]) begin
        inv_found <= 1'b1;
        inv_way   <= pend_i;
      end
      if (pend_i == '0 || rank_q < min_rank) begin
        min_rank <= rank_q;
        min_way  <= pend_i;
      end
    end

    if (emit) begin
      sel_way     <= dec_way;
      sel_hit     <= hit_found;
      wr_i        <= '0;
      rsp_outcome <= dec_outcome;
      rsp_way     <= dec_way;
      rsp_last    <= !func_q || pass;
    end else if (state == ST_UPD) begin
      wr_i <= wr_i + 1'b1;
    end
  end

  // line stores
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[wr_addr] <= tag_wd;
    tag_q <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[wr_addr] <= rank_wd;
    rank_q <= rank_mem[rd_addr];
  end

  assign outcome        = rsp_outcome;
  assign way_used       = rsp_way;
  assign hit_total      = hits_seen;
  assign miss_total     = misses_seen;
  assign eviction_total = evictions_seen;
  assign last_of_run    = rsp_last;

endmodule
